@@ src/stt_pkg.sv @@
package stt_pkg;

    localparam int LEN_W = 8;
    localparam int FIELD_POS_W = 16;

    typedef enum logic [2:0] {
        EV_WORD_BYTE = 3'd0,
        EV_WORD_DONE = 3'd1,
        EV_SINGLE    = 3'd2,
        EV_BAD_BYTE  = 3'd3,
        EV_END_TEXT  = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_STAR   = 3'd4
    } scan_mode_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef struct packed {
        logic                   last;
        logic [LEN_W-1:0]       len;
        logic [FIELD_POS_W-1:0] column;
        logic [FIELD_POS_W-1:0] line;
        logic [7:0]             token_byte;
        event_t                 ev;
    } result_t;

    function automatic logic is_word_byte(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER;
    endfunction

    function automatic logic is_single(logic [7:0] c);
        return c == 8'h3D || c == 8'h2B || c == 8'h21 || c == 8'h3C || c == 8'h3E ||
               c == 8'h3B || c == 8'h28 || c == 8'h29 || c == 8'h7B || c == 8'h7D;
    endfunction

    function automatic result_t make_result(event_t ev, logic [7:0] b,
                                            logic [FIELD_POS_W-1:0] ln,
                                            logic [FIELD_POS_W-1:0] col,
                                            logic [LEN_W-1:0] len);
        result_t r;
        r.last       = 1'b0;
        r.len        = len;
        r.column     = col;
        r.line       = ln;
        r.token_byte = b;
        r.ev         = ev;
        return r;
    endfunction

endpackage

@@ src/stt_lexer.sv @@
module stt_lexer
    import stt_pkg::*;
#(
    parameter int MAX_WORD      = 255,
    parameter int POSITION_BITS = 16
) (
    input  scan_mode_t               mode_i,
    input  logic [LEN_W-1:0]         word_len_i,
    input  logic [POSITION_BITS-1:0] line_i,
    input  logic [POSITION_BITS-1:0] col_i,
    input  logic [POSITION_BITS-1:0] start_col_i,
    input  logic [3:0]               tab_width_i,
    input  logic [7:0]               ch_i,
    input  logic                     eoi_i,
    output scan_mode_t               mode_o,
    output logic [LEN_W-1:0]         word_len_o,
    output logic [POSITION_BITS-1:0] line_o,
    output logic [POSITION_BITS-1:0] col_o,
    output logic [POSITION_BITS-1:0] start_col_o,
    output result_t                  res_o [2],
    output logic [1:0]               count_o
);

    localparam int PB = POSITION_BITS;
    localparam int WB = (PB > FIELD_POS_W) ? PB : FIELD_POS_W;
    localparam logic [PB-1:0] POS_ONE = PB'(1);

    function automatic logic [PB-1:0] sat_add(logic [PB-1:0] a, logic [PB-1:0] b);
        logic [PB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PB] ? {PB{1'b1}} : s[PB-1:0];
    endfunction

    function automatic logic [FIELD_POS_W-1:0] to_field(logic [PB-1:0] v);
        logic [WB-1:0] w;
        w = WB'(v);
        return w[FIELD_POS_W-1:0];
    endfunction

    logic [PB-1:0] col_1, col_2, col_t, col_base, col_b1, col_bt, line_1;
    logic          word_full;

    assign col_1    = sat_add(col_i, POS_ONE);
    assign col_2    = sat_add(col_i, PB'(2));
    assign col_t    = sat_add(col_i, PB'(tab_width_i));
    assign col_base = (mode_i == MODE_SLASH) ? col_1 : col_i;
    assign col_b1   = sat_add(col_base, POS_ONE);
    assign col_bt   = sat_add(col_base, PB'(tab_width_i));
    assign line_1   = sat_add(line_i, POS_ONE);
    assign word_full = word_len_i >= LEN_W'(MAX_WORD);

    always_comb begin
        mode_o = mode_i;
        if (eoi_i) begin
            mode_o = MODE_NORMAL;
        end else begin
            unique case (mode_i)
                MODE_LINE: begin
                    if (ch_i == CH_NL) mode_o = MODE_NORMAL;
                end
                MODE_BLOCK: begin
                    mode_o = (ch_i == CH_STAR) ? MODE_STAR : MODE_BLOCK;
                end
                MODE_STAR: begin
                    if (ch_i == CH_SLASH) mode_o = MODE_NORMAL;
                    else if (ch_i == CH_STAR) mode_o = MODE_STAR;
                    else mode_o = MODE_BLOCK;
                end
                MODE_SLASH: begin
                    if (ch_i == CH_SLASH) mode_o = MODE_LINE;
                    else if (ch_i == CH_STAR) mode_o = MODE_BLOCK;
                    else mode_o = MODE_NORMAL;
                end
                default: begin
                    mode_o = (ch_i == CH_SLASH) ? MODE_SLASH : MODE_NORMAL;
                end
            endcase
        end
    end

    always_comb begin
        logic [1:0] n;
        logic       do_normal;
        result_t    word_done;
        n           = 2'd0;
        do_normal   = 1'b0;
        res_o[0]    = '0;
        res_o[1]    = '0;
        word_len_o  = word_len_i;
        line_o      = line_i;
        col_o       = col_i;
        start_col_o = start_col_i;
        word_done   = make_result(EV_WORD_DONE, 8'd0, to_field(line_i),
                                  to_field(start_col_i), word_len_i);
        if (eoi_i) begin
            if (mode_i == MODE_NORMAL && word_len_i != '0) begin
                res_o[n[0]] = word_done;
                n = n + 2'd1;
            end else if (mode_i == MODE_SLASH) begin
                res_o[n[0]] = make_result(EV_SINGLE, CH_SLASH, to_field(line_i),
                                          to_field(col_i), LEN_W'(1));
                n = n + 2'd1;
            end
            res_o[n[0]] = make_result(EV_END_TEXT, 8'd0, to_field(line_i),
                                      to_field(col_i), '0);
            n = n + 2'd1;
            word_len_o  = '0;
            line_o      = POS_ONE;
            col_o       = POS_ONE;
            start_col_o = POS_ONE;
        end else begin
            unique case (mode_i)
                MODE_SLASH: begin
                    if (ch_i == CH_SLASH || ch_i == CH_STAR) begin
                        col_o = col_2;
                    end else begin
                        res_o[n[0]] = make_result(EV_SINGLE, CH_SLASH, to_field(line_i),
                                                  to_field(col_i), LEN_W'(1));
                        n = n + 2'd1;
                        do_normal = 1'b1;
                    end
                end
                MODE_LINE: begin
                    if (ch_i == CH_NL) begin
                        line_o = line_1;
                        col_o  = POS_ONE;
                    end
                end
                MODE_BLOCK, MODE_STAR: begin
                    if (ch_i == CH_NL) begin
                        line_o = line_1;
                        col_o  = POS_ONE;
                    end else if (ch_i == CH_TAB) begin
                        col_o = col_t;
                    end else begin
                        col_o = col_1;
                    end
                end
                default: begin
                    do_normal = 1'b1;
                end
            endcase
            if (do_normal) begin
                if (is_word_byte(ch_i)) begin
                    if (word_full) begin
                        res_o[n[0]] = word_done;
                        n = n + 2'd1;
                    end
                    if (word_full || word_len_i == '0) start_col_o = col_base;
                    res_o[n[0]] = make_result(EV_WORD_BYTE, ch_i, to_field(line_i),
                                              to_field(col_base), LEN_W'(1));
                    n = n + 2'd1;
                    word_len_o = word_full ? LEN_W'(1) : word_len_i + LEN_W'(1);
                    col_o = col_b1;
                end else begin
                    if (word_len_i != '0) begin
                        res_o[n[0]] = word_done;
                        n = n + 2'd1;
                    end
                    word_len_o = '0;
                    col_o = col_base;
                    if (ch_i == CH_SPACE) begin
                        col_o = col_b1;
                    end else if (ch_i == CH_TAB) begin
                        col_o = col_bt;
                    end else if (ch_i == CH_NL) begin
                        line_o = line_1;
                        col_o  = POS_ONE;
                    end else if (ch_i != CH_SLASH) begin
                        res_o[n[0]] = make_result(is_single(ch_i) ? EV_SINGLE : EV_BAD_BYTE,
                                                  ch_i, to_field(line_i),
                                                  to_field(col_base), LEN_W'(1));
                        n = n + 2'd1;
                        col_o = col_b1;
                    end
                end
            end
        end
        if (n == 2'd2) res_o[1].last = 1'b1;
        else if (n == 2'd1) res_o[0].last = 1'b1;
        count_o = n;
    end

endmodule

@@ src/source_text_tokenizer.sv @@
// Source text tokenizer. Text bytes enter on the s_ channel, one beat per byte, with
// s_tlast marking the end of the text. Each byte is decoded in the cycle it is taken
// and causes zero, one or two result beats on the m_ channel: word bytes, word done,
// one-byte tokens, bad bytes and end of text, each with line, column and length, and
// m_tlast set on the last beat a byte causes. A two-entry result buffer follows the
// decoder, so a byte is taken every cycle while each byte yields at most one beat and
// the sink keeps up; a two-beat byte holds the input until its first beat is taken.
// The user must write the tab width on the cfg_ port while idle; the block does not check.
module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int MAX_WORD      = 255,
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] token_byte, [23:8] line, [39:24] column,
                                   // [47:40] length
    output logic [2:0]  m_tuser,   // [2:0] event_res
    output logic        m_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    localparam int PB = POSITION_BITS;

    scan_mode_t       mode_reg, mode_next;
    logic [LEN_W-1:0] word_len_reg, word_len_next;
    logic [PB-1:0]    line_reg, line_next;
    logic [PB-1:0]    col_reg, col_next;
    logic [PB-1:0]    start_col_reg, start_col_next;
    logic [3:0]       tab_width_reg;

    result_t          new_res [2];
    logic [1:0]       new_count;
    result_t          slot_reg [2];
    logic [1:0]       out_cnt_reg;
    logic             in_acc, out_pop;

    stt_lexer #(
        .MAX_WORD      (MAX_WORD),
        .POSITION_BITS (POSITION_BITS)
    ) u_lexer (
        .mode_i      (mode_reg),
        .word_len_i  (word_len_reg),
        .line_i      (line_reg),
        .col_i       (col_reg),
        .start_col_i (start_col_reg),
        .tab_width_i (tab_width_reg),
        .ch_i        (s_tdata),
        .eoi_i       (s_tlast),
        .mode_o      (mode_next),
        .word_len_o  (word_len_next),
        .line_o      (line_next),
        .col_o       (col_next),
        .start_col_o (start_col_next),
        .res_o       (new_res),
        .count_o     (new_count)
    );

    assign s_tready  = (out_cnt_reg == 2'd0) || (out_cnt_reg == 2'd1 && m_tready);
    assign in_acc    = s_tvalid && s_tready;
    assign m_tvalid  = out_cnt_reg != 2'd0;
    assign out_pop   = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    assign m_tdata = {slot_reg[0].len, slot_reg[0].column, slot_reg[0].line,
                      slot_reg[0].token_byte};
    assign m_tuser = slot_reg[0].ev;
    assign m_tlast = slot_reg[0].last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_NORMAL;
            word_len_reg  <= '0;
            line_reg      <= PB'(1);
            col_reg       <= PB'(1);
            start_col_reg <= PB'(1);
            tab_width_reg <= 4'd4;
            out_cnt_reg   <= 2'd0;
        end else begin
            if (cfg_valid && cfg_ready) tab_width_reg <= cfg_data;
            if (in_acc) begin
                mode_reg      <= mode_next;
                word_len_reg  <= word_len_next;
                line_reg      <= line_next;
                col_reg       <= col_next;
                start_col_reg <= start_col_next;
                out_cnt_reg   <= new_count;
            end else if (out_pop) begin
                out_cnt_reg <= out_cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            slot_reg[0] <= new_res[0];
            slot_reg[1] <= new_res[1];
        end else if (out_pop) begin
            slot_reg[0] <= slot_reg[1];
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_head_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg == 2'd2 |-> !slot_reg[0].last)
        else $error("first of two buffered beats is marked last");

    a_tail_last: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && new_count != 2'd0 |=> m_tvalid && (out_cnt_reg == 2'd1 ? m_tlast :
                                                      slot_reg[1].last))
        else $error("last beat of a byte is not marked last");

    a_eot_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && s_tlast |=> mode_reg == MODE_NORMAL && word_len_reg == '0 &&
                              line_reg == PB'(1) && col_reg == PB'(1))
        else $error("scan state not cleared after end of text");

    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg != '0 && col_reg != '0)
        else $error("position counter reached zero");

endmodule
